FILE: rtl/core/scba_pkg.sv
`default_nettype none
package scba_pkg;

  localparam int ACT_W  = 2;
  localparam int SIZE_W = 16;
  localparam int ADDR_W = 18;
  localparam int ST_W   = 2;

  // defaults for the top level parameters
  localparam int DEF_PAGE_BYTES = 4096;
  localparam int DEF_POOL_PAGES = 64;
  localparam int DEF_WORD_BYTES = 8;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REALLOC = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RSVD    = 2'd3;

  // status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFIT  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOPAGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FREED  = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [ST_W-1:0]   status;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/core/scba_ram.sv
`default_nettype none
// single-port-write, single-port-read RAM, registered read data
module scba_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/scba_size_class.sv
`default_nettype none
// smallest size class whose block holds the request
module scba_size_class #(
  parameter int WORD_BYTES = 8,
  parameter int NCLS       = 8
) (
  input  wire logic [15:0]               size,
  output logic                           fit,
  output logic      [$clog2(NCLS)-1:0]   cls
);

  import scba_pkg::*;

  localparam int CW = $clog2(NCLS);

  always_comb begin
    fit = 1'b0;
    cls = '0;
    // walk down so the lowest fitting class wins
    for (int c = NCLS - 1; c >= 0; c--) begin
      if (17'(WORD_BYTES << c) >= {1'b0, size}) begin
        fit = 1'b1;
        cls = CW'(c);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/size_class_block_allocator_unit.sv
// Size-class block allocator.
// Input channel in_valid/in_ready/in_data carries one request item: allocate,
// free or reallocate. Output channel out_valid/out_ready/out_data returns one
// item per request: block address (0 when none) and status.
// Block sizes are WORD_BYTES << class up to a quarter page; the first block of
// every page is a header, so address 0 never names a block.
// Path from the accepting edge to out_valid: the reserved action goes straight
// to S_OUT; an allocate that carves, takes a fresh page or fails passes S_ALLOC,
// one popping a free stack also S_POP (link RAM read); a free passes S_FREE
// (page-owner RAM read) and S_FREE2 if its address lies in a handed-out page;
// a reallocate runs the allocate and then the free path. One item is in flight
// at a time and in_ready returns the cycle after out_data is loaded.
// The result sits in an output register; the next item is accepted while it
// waits and only stalls at its final step if the receiver still holds off.
// Reset (rst_n low, synchronous) empties all free stacks, gives page i to
// class i with its carve pointer after the header and sets the handed-out
// count to the class count. Neither RAM needs clearing: a link is only read
// for a pushed block, reset pages take their class from the page number and
// later pages are written when handed out. PAGE_BYTES and WORD_BYTES are
// powers of two.
`default_nettype none
module size_class_block_allocator_unit #(
  parameter int PAGE_BYTES = scba_pkg::DEF_PAGE_BYTES,
  parameter int POOL_PAGES = scba_pkg::DEF_POOL_PAGES,
  parameter int WORD_BYTES = scba_pkg::DEF_WORD_BYTES
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire scba_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output scba_pkg::out_item_t      out_data
);

  import scba_pkg::*;

  localparam int PB   = $clog2(PAGE_BYTES);           // page offset bits
  localparam int WB   = $clog2(WORD_BYTES);           // word offset bits
  localparam int NCLS = PB - 1 - WB;                  // classes up to page/4
  localparam int CW   = $clog2(NCLS);
  localparam int PGW  = $clog2(POOL_PAGES);           // page index
  localparam int HW   = $clog2(POOL_PAGES + 1);       // handed-out count
  localparam int PW   = PB + PGW;                     // pool pointer
  localparam int EW   = (ADDR_W > PW) ? ADDR_W : PW;  // compare width
  localparam int LINK_DEPTH = POOL_PAGES * (PAGE_BYTES / WORD_BYTES);
  localparam int LW   = $clog2(LINK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_POP,
    S_FREE,
    S_FREE2,
    S_OUT
  } state_t;

  state_t            state_r;
  logic [ACT_W-1:0]  act_r;
  logic [ADDR_W-1:0] addr_r;
  logic              fit_r;
  logic [CW-1:0]     cls_r;
  logic [PW-1:0]     res_r;
  logic [ST_W-1:0]   st_r;
  logic [HW-1:0]     handed_r;
  logic [PW-1:0]     head_r  [NCLS];
  logic [PW-1:0]     carve_r [NCLS];
  logic              out_valid_r;
  out_item_t         out_data_r;

  // request size -> class
  logic          cls_fit;
  logic [CW-1:0] cls_sel;

  scba_size_class #(
    .WORD_BYTES (WORD_BYTES),
    .NCLS       (NCLS)
  ) u_size_class (
    .size (in_data.request_size),
    .fit  (cls_fit),
    .cls  (cls_sel)
  );

  // allocate path
  logic [PW-1:0] head_sel, carve_sel, bs_a, carve_sum, carve_nxt, fresh_addr;
  logic          alloc_pop, alloc_carve, alloc_fresh, pool_left;
  state_t        after_alloc;

  always_comb begin
    head_sel    = head_r[cls_r];
    carve_sel   = carve_r[cls_r];
    bs_a        = PW'(WORD_BYTES) << cls_r;
    carve_sum   = carve_sel + bs_a;
    // page used up once the next block would start a new page
    carve_nxt   = (carve_sum[PB-1:0] == '0) ? '0 : carve_sum;
    fresh_addr  = (PW'(handed_r[PGW-1:0]) << PB) + bs_a;
    pool_left   = handed_r < HW'(POOL_PAGES);
    alloc_pop   = fit_r && (head_sel != '0);
    alloc_carve = fit_r && (head_sel == '0) && (carve_sel != '0);
    alloc_fresh = fit_r && (head_sel == '0) && (carve_sel == '0) && pool_left;
    // a reallocate frees the old block once the allocate is done
    after_alloc = (act_r == ACT_REALLOC) ? S_FREE : S_OUT;
  end

  // free path
  logic [EW-1:0] page_ext;
  logic          free_ok, free_low, off_ok;
  logic [CW-1:0] free_cls;
  logic [CW-1:0] owner_rdata;
  logic [PW-1:0] addr_p, bs_f, blk_f;

  always_comb begin
    page_ext = EW'(addr_r) >> PB;
    free_ok  = (addr_r != '0) && (page_ext < EW'(handed_r));
    free_low = page_ext < EW'(NCLS);
    // reset pages belong to the class of their own number
    free_cls = free_low ? CW'(page_ext) : owner_rdata;
    addr_p   = PW'(addr_r);
    bs_f     = PW'(WORD_BYTES) << free_cls;
    off_ok   = addr_p[PB-1:0] >= bs_f[PB-1:0];  // not inside the header
    blk_f    = addr_p & ~(bs_f - PW'(1));
  end

  // link RAM: next pointer of every free block
  logic          link_we;
  logic [PW-1:0] link_rdata;

  assign link_we = (state_r == S_FREE2) && off_ok;

  scba_ram #(
    .WIDTH (PW),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk     (clk),
    .we      (link_we),
    .waddr   (blk_f[WB +: LW]),
    .wdata   (head_r[free_cls]),
    .raddr   (head_sel[WB +: LW]),
    .rdata_r (link_rdata)
  );

  // page-owner RAM: class of each page handed out after reset
  logic owner_we;

  assign owner_we = (state_r == S_ALLOC) && alloc_fresh;

  scba_ram #(
    .WIDTH (CW),
    .DEPTH (POOL_PAGES)
  ) u_owner_ram (
    .clk     (clk),
    .we      (owner_we),
    .waddr   (handed_r[PGW-1:0]),
    .wdata   (cls_r),
    .raddr   (page_ext[PGW-1:0]),
    .rdata_r (owner_rdata)
  );

  // result register loads once it is empty or being taken
  logic out_load;

  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      handed_r    <= HW'(NCLS);
      for (int c = 0; c < NCLS; c++) begin
        head_r[c]  <= '0;
        carve_r[c] <= PW'(c * PAGE_BYTES + (WORD_BYTES << c));
      end
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r  <= in_data.action;
            addr_r <= in_data.block_address;
            fit_r  <= cls_fit;
            cls_r  <= cls_sel;
            res_r  <= '0;
            unique case (in_data.action)
              ACT_ALLOC, ACT_REALLOC: begin
                st_r    <= ST_OK;
                state_r <= S_ALLOC;
              end
              ACT_FREE: begin
                st_r    <= ST_FREED;
                state_r <= S_FREE;
              end
              ACT_RSVD: begin
                st_r    <= ST_NOFIT;
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (alloc_pop) begin
            res_r   <= head_sel;
            state_r <= S_POP;  // wait for the link read
          end else begin
            state_r <= after_alloc;
            if (!fit_r) begin
              st_r <= ST_NOFIT;
            end else if (alloc_carve) begin
              res_r          <= carve_sel;
              carve_r[cls_r] <= carve_nxt;
            end else if (alloc_fresh) begin
              res_r          <= fresh_addr;
              carve_r[cls_r] <= fresh_addr + bs_a;
              handed_r       <= handed_r + HW'(1);
            end else begin
              st_r <= ST_NOPAGE;
            end
          end
        end
        S_POP: begin
          head_r[cls_r] <= link_rdata;
          state_r       <= after_alloc;
        end
        S_FREE: begin
          // owner read issued on addr_r this cycle
          state_r <= free_ok ? S_FREE2 : S_OUT;
        end
        S_FREE2: begin
          if (off_ok) begin
            head_r[free_cls] <= blk_f;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_data_r.result_address  <= ADDR_W'(res_r);
            out_data_r.status          <= st_r;
            state_r                    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/scba_chk.sv
`default_nettype none
module scba_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire scba_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire scba_pkg::out_item_t out_data
);

  import scba_pkg::*;

  // nothing shown right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed under stall");

  // one item at a time: input closes after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // only a successful allocation yields an address
  a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.result_address == '0)
    else $error("address with non-ok status");

  // a block is never the header of page zero
  a_ok_nonnull: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_OK) |-> out_data.result_address != '0)
    else $error("null address with ok status");

endmodule

bind size_class_block_allocator_unit scba_chk u_scba_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
